// File: rtl/rte_pkg.sv
// Shared types, constants and helper functions for the RISC-V trap entry unit.
// Used by every module under rtl; depends on nothing else.

package rte_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MTVEC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STVEC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDELEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDELEG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IE_MASK = 3'd4;

    // Request types.
    localparam logic REQ_EXCEPTION = 1'b0;
    localparam logic REQ_INTERRUPT = 1'b1;

    // Privilege modes.
    localparam logic [1:0] MODE_USER    = 2'd0;
    localparam logic [1:0] MODE_SUPER   = 2'd1;
    localparam logic [1:0] MODE_MACHINE = 2'd3;

    // Interrupt bit positions.
    localparam logic [3:0] IRQ_USI = 4'd0;
    localparam logic [3:0] IRQ_SSI = 4'd1;
    localparam logic [3:0] IRQ_MSI = 4'd3;
    localparam logic [3:0] IRQ_UTI = 4'd4;
    localparam logic [3:0] IRQ_STI = 4'd5;
    localparam logic [3:0] IRQ_MTI = 4'd7;
    localparam logic [3:0] IRQ_UEI = 4'd8;
    localparam logic [3:0] IRQ_SEI = 4'd9;
    localparam logic [3:0] IRQ_MEI = 4'd11;

    localparam int unsigned NUM_PRIO = 9;
    localparam logic [3:0] IRQ_PRIO [NUM_PRIO] = '{
        IRQ_MEI, IRQ_MSI, IRQ_MTI, IRQ_SEI, IRQ_SSI,
        IRQ_STI, IRQ_UEI, IRQ_USI, IRQ_UTI
    };

    // Exception causes that carry a trap value.
    localparam logic [3:0] CAUSE_INSTR_ACCESS_FAULT = 4'd1;
    localparam logic [3:0] CAUSE_LOAD_MISALIGNED    = 4'd4;
    localparam logic [3:0] CAUSE_LOAD_ACCESS_FAULT  = 4'd5;
    localparam logic [3:0] CAUSE_STORE_MISALIGNED   = 4'd6;
    localparam logic [3:0] CAUSE_STORE_ACCESS_FAULT = 4'd7;
    localparam logic [3:0] CAUSE_INSTR_PAGE_FAULT   = 4'd12;
    localparam logic [3:0] CAUSE_LOAD_PAGE_FAULT    = 4'd13;
    localparam logic [3:0] CAUSE_STORE_PAGE_FAULT   = 4'd15;

    typedef struct packed {
        logic [63:0] mtvec;
        logic [63:0] stvec;
        logic [15:0] edeleg;
        logic [11:0] ideleg;
        logic [11:0] ie_mask;
    } rte_cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  cause_code;
        logic [63:0] current_pc;
        logic [63:0] fault_value;
        logic [11:0] pending_irqs;
        logic [1:0]  current_mode;
        logic        machine_int_enable;
        logic        super_int_enable;
    } rte_item_t;

    typedef struct packed {
        logic        trap_taken;
        logic        to_supervisor;
        logic [63:0] target_pc;
        logic [63:0] cause_value;
        logic [63:0] saved_pc;
        logic [63:0] trap_value;
        logic [1:0]  previous_mode;
        logic        previous_enable;
        logic [1:0]  new_mode;
    } rte_result_t;

    // True for fault and misaligned causes, whose trap value is reported.
    function automatic logic keeps_value(input logic [3:0] code);
        logic keep;
        keep = 1'b0;
        case (code) inside
            CAUSE_INSTR_ACCESS_FAULT, CAUSE_LOAD_MISALIGNED,
            CAUSE_LOAD_ACCESS_FAULT, CAUSE_STORE_MISALIGNED,
            CAUSE_STORE_ACCESS_FAULT, CAUSE_INSTR_PAGE_FAULT,
            CAUSE_LOAD_PAGE_FAULT, CAUSE_STORE_PAGE_FAULT:
                keep = 1'b1;
            default:
                keep = 1'b0;
        endcase
        return keep;
    endfunction

endpackage

// File: rtl/rte_cfg_regs.sv
// Configuration register file of the trap entry unit (vectors, delegation, enables).
// Depends on rte_pkg.

module rte_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [rte_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [63:0]                   wr_data,
    output rte_pkg::rte_cfg_t             cfg
);
    import rte_pkg::*;

    rte_cfg_t cfg_reg;
    rte_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_MTVEC:   cfg_next.mtvec   = wr_data;
                CFG_STVEC:   cfg_next.stvec   = wr_data;
                CFG_EDELEG:  cfg_next.edeleg  = wr_data[15:0];
                CFG_IDELEG:  cfg_next.ideleg  = wr_data[11:0];
                CFG_IE_MASK: cfg_next.ie_mask = wr_data[11:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/rte_trap_logic.sv
// Combinational trap entry computation: interrupt selection, delegation and vector pc.
// Depends on rte_pkg.

module rte_trap_logic (
    input  rte_pkg::rte_cfg_t    cfg,
    input  rte_pkg::rte_item_t   item,
    output rte_pkg::rte_result_t result
);
    import rte_pkg::*;

    logic [11:0] active;
    logic [11:0] qual;
    logic        ge_deleg;
    logic        ge_mach;
    logic        irq_found;
    logic [3:0]  irq_sel;
    logic        is_int;
    logic        found;
    logic [3:0]  code;
    logic [15:0] deleg_vec;
    logic        to_s;
    logic [63:0] tvec;
    logic [63:0] base;

    always_comb
    begin
        active   = item.pending_irqs & cfg.ie_mask;
        ge_deleg = (item.current_mode == MODE_SUPER && item.super_int_enable)
                   || (item.current_mode == MODE_USER);
        ge_mach  = (item.current_mode == MODE_MACHINE && item.machine_int_enable)
                   || (item.current_mode != MODE_MACHINE);
        for (int i = 0; i < 12; i++)
        begin
            qual[i] = active[i] & (cfg.ideleg[i] ? ge_deleg : ge_mach);
        end

        // Scan from lowest to highest priority so the highest one wins.
        irq_found = 1'b0;
        irq_sel   = '0;
        for (int k = NUM_PRIO - 1; k >= 0; k--)
        begin
            if (qual[IRQ_PRIO[k]])
            begin
                irq_found = 1'b1;
                irq_sel   = IRQ_PRIO[k];
            end
        end

        is_int    = (item.req_type == REQ_INTERRUPT);
        found     = !is_int || irq_found;
        code      = is_int ? irq_sel : item.cause_code;
        deleg_vec = is_int ? {4'b0, cfg.ideleg} : cfg.edeleg;
        to_s      = deleg_vec[code] && (item.current_mode != MODE_MACHINE);
        tvec      = to_s ? cfg.stvec : cfg.mtvec;
        base      = {tvec[63:2], 2'b00};

        result = '0;
        if (found)
        begin
            result.trap_taken      = 1'b1;
            result.to_supervisor   = to_s;
            result.target_pc       = (is_int && tvec[0]) ? base + {58'b0, code, 2'b00}
                                                         : base;
            result.cause_value     = {is_int, 59'b0, code};
            result.saved_pc        = item.current_pc;
            result.trap_value      = (!is_int && keeps_value(code)) ? item.fault_value
                                                                    : 64'b0;
            result.previous_mode   = item.current_mode;
            result.previous_enable = to_s ? item.super_int_enable : item.machine_int_enable;
            result.new_mode        = to_s ? MODE_SUPER : MODE_MACHINE;
        end
    end

endmodule

// File: rtl/riscv_trap_entry_unit.sv
// Top level of the RISC-V trap entry unit: request register, trap logic, result register.
// Depends on rte_pkg, rte_cfg_regs and rte_trap_logic.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+--------------------------------------------
//   request  | in_valid / in_stall    | req_type ... super_int_enable
//   result   | out_valid / out_stall  | trap_taken ... new_mode
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request enters per cycle while in_stall is low. It is captured in the
// request register, the trap decision is made by one level of priority logic
// and a 64-bit add, and the outcome lands in the result register, whose valid
// flag is out_valid.
// Reset clears the valid flags and the configuration registers.
// A stalled result holds; the request register still fills behind it, and
// in_stall rises only when both registers are occupied and the output stalls.

module riscv_trap_entry_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [3:0]                    cause_code,
    input  logic [63:0]                   current_pc,
    input  logic [63:0]                   fault_value,
    input  logic [11:0]                   pending_irqs,
    input  logic [1:0]                    current_mode,
    input  logic                          machine_int_enable,
    input  logic                          super_int_enable,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          trap_taken,
    output logic                          to_supervisor,
    output logic [63:0]                   target_pc,
    output logic [63:0]                   cause_value,
    output logic [63:0]                   saved_pc,
    output logic [63:0]                   trap_value,
    output logic [1:0]                    previous_mode,
    output logic                          previous_enable,
    output logic [1:0]                    new_mode,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import rte_pkg::*;

    rte_cfg_t    cfg;
    rte_item_t   item_reg;
    rte_item_t   item_next;
    logic        item_valid_reg;
    logic        item_valid_next;
    rte_result_t result_reg;
    rte_result_t result_next;
    rte_result_t result_comb;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_accept;
    logic        result_load;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    rte_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rte_trap_logic u_trap_logic (
        .cfg    (cfg),
        .item   (item_reg),
        .result (result_comb)
    );

    // The held request moves on whenever the result register is empty or
    // its content is being taken in this cycle.
    assign result_load = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = item_valid_reg && !result_load;
    assign in_accept   = in_valid && !in_stall;

    always_comb
    begin
        item_next                    = item_reg;
        item_valid_next              = item_valid_reg && !result_load;
        if (in_accept)
        begin
            item_next.req_type           = req_type;
            item_next.cause_code         = cause_code;
            item_next.current_pc         = current_pc;
            item_next.fault_value        = fault_value;
            item_next.pending_irqs       = pending_irqs;
            item_next.current_mode       = current_mode;
            item_next.machine_int_enable = machine_int_enable;
            item_next.super_int_enable   = super_int_enable;
            item_valid_next              = 1'b1;
        end
    end

    always_comb
    begin
        result_next    = result_load ? result_comb : result_reg;
        out_valid_next = item_valid_reg || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign trap_taken      = result_reg.trap_taken;
    assign to_supervisor   = result_reg.to_supervisor;
    assign target_pc       = result_reg.target_pc;
    assign cause_value     = result_reg.cause_value;
    assign saved_pc        = result_reg.saved_pc;
    assign trap_value      = result_reg.trap_value;
    assign previous_mode   = result_reg.previous_mode;
    assign previous_enable = result_reg.previous_enable;
    assign new_mode        = result_reg.new_mode;

endmodule

// File: rtl/rte_checker.sv
// Port-level checks for the trap entry unit, attached to the top level by bind.
// Depends on rte_pkg and riscv_trap_entry_unit.

module rte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        trap_taken,
    input logic        to_supervisor,
    input logic [63:0] target_pc,
    input logic [63:0] cause_value,
    input logic [63:0] saved_pc,
    input logic [63:0] trap_value,
    input logic [1:0]  previous_mode,
    input logic [1:0]  new_mode
);
    import rte_pkg::*;

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cause_value) && $stable(target_pc))
        else $error("stalled result changed or dropped");

    // When no interrupt qualifies, the pc, cause and trap value fields, to_supervisor and new_mode are all zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !trap_taken |-> target_pc == 64'b0 && cause_value == 64'b0
            && saved_pc == 64'b0 && trap_value == 64'b0 && !to_supervisor
            && new_mode == MODE_USER)
        else $error("non-trap result carries data");

    // The new mode follows the handling level.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trap_taken |-> (to_supervisor && new_mode == MODE_SUPER)
            || (!to_supervisor && new_mode == MODE_MACHINE))
        else $error("new mode disagrees with target level");

    // Interrupts never report a trap value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trap_taken && cause_value[63] |-> trap_value == 64'b0)
        else $error("interrupt with nonzero trap value");

    // A trap is never delegated away from machine mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && to_supervisor |-> previous_mode != MODE_MACHINE)
        else $error("delegated trap taken from machine mode");

endmodule

bind riscv_trap_entry_unit rte_checker u_rte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trap_taken    (trap_taken),
    .to_supervisor (to_supervisor),
    .target_pc     (target_pc),
    .cause_value   (cause_value),
    .saved_pc      (saved_pc),
    .trap_value    (trap_value),
    .previous_mode (previous_mode),
    .new_mode      (new_mode)
);

// File: test/tb_riscv_trap_entry_unit.sv
// Self-checking testbench for riscv_trap_entry_unit: directed and random trap requests,
// each result compared in order against an independent prediction of the trap entry.
// Depends on rte_pkg and the riscv_trap_entry_unit top level only.

module tb_riscv_trap_entry_unit;

    import rte_pkg::*;

    // A block that stops accepting anything for this many cycles is considered hung.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Requests per random phase; eight phases give about 1200 random requests.
    localparam int unsigned PHASE_REQS = 150;
    localparam int unsigned NUM_RAND_PHASES = 8;
    // Every this many launched requests the sender waits for the pipeline to drain.
    localparam int unsigned DRAIN_EVERY = 200;
    // Mismatch lines printed before the report goes quiet (counting continues).
    localparam int unsigned PRINT_LIMIT = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = REQ_EXCEPTION;
    logic [3:0]           cause_code = '0;
    logic [63:0]          current_pc = '0;
    logic [63:0]          fault_value = '0;
    logic [11:0]          pending_irqs = '0;
    logic [1:0]           current_mode = MODE_MACHINE;
    logic                 machine_int_enable = 1'b0;
    logic                 super_int_enable = 1'b0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 trap_taken;
    logic                 to_supervisor;
    logic [63:0]          target_pc;
    logic [63:0]          cause_value;
    logic [63:0]          saved_pc;
    logic [63:0]          trap_value;
    logic [1:0]           previous_mode;
    logic                 previous_enable;
    logic [1:0]           new_mode;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MTVEC;
    logic [63:0]          cfg_data = '0;

    // Our own image of the trap CSRs held by the block; it starts at the reset values.
    rte_cfg_t    csr_image = '0;
    // Requests waiting to be offered, and the trap entries predicted for accepted ones.
    rte_item_t   pending_reqs [$];
    rte_result_t expected_traps [$];
    // The request currently on the input port.
    rte_item_t   drive_req = '0;

    // Both counters move with nonblocking updates so that readers at a clock edge
    // always see the values from before that edge.
    int unsigned requests_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned launched = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          drain_hold = 1'b0;
    bit          idle_on = 1'b1;

    riscv_trap_entry_unit dut (.*);

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction of one trap entry from a request and the CSR image.
    // ------------------------------------------------------------------
    function automatic rte_result_t predict_trap(input rte_item_t rq, input rte_cfg_t csr);
        rte_result_t r;
        logic [11:0] active;
        logic        found;
        logic        is_irq;
        logic        deleg;
        logic        gate;
        logic        to_s;
        logic        keep;
        logic [3:0]  code;
        logic [3:0]  irq;
        logic [63:0] tvec;
        r = '0;
        found = rq.req_type == REQ_EXCEPTION;
        is_irq = 1'b0;
        code = rq.cause_code;
        if (!found) begin
            active = rq.pending_irqs & csr.ie_mask;
            // Walk the fixed priority order; the first enabled interrupt whose global
            // enable qualifies in the current mode wins.
            for (int k = 0; k < NUM_PRIO; k++) begin
                irq = IRQ_PRIO[k];
                if (!found && active[irq]) begin
                    deleg = csr.ideleg[irq];
                    if (deleg)
                        gate = (rq.current_mode == MODE_SUPER && rq.super_int_enable)
                               || rq.current_mode == MODE_USER;
                    else
                        gate = (rq.current_mode == MODE_MACHINE && rq.machine_int_enable)
                               || rq.current_mode != MODE_MACHINE;
                    if (gate) begin
                        found = 1'b1;
                        is_irq = 1'b1;
                        code = irq;
                    end
                end
            end
        end
        if (!found)
            return r;

        // The reserved mode counts as below machine, so delegation applies to it.
        to_s = (is_irq ? csr.ideleg[code] : csr.edeleg[code])
               && rq.current_mode != MODE_MACHINE;
        tvec = to_s ? csr.stvec : csr.mtvec;

        case (code)
            CAUSE_INSTR_ACCESS_FAULT, CAUSE_LOAD_MISALIGNED, CAUSE_LOAD_ACCESS_FAULT,
            CAUSE_STORE_MISALIGNED, CAUSE_STORE_ACCESS_FAULT, CAUSE_INSTR_PAGE_FAULT,
            CAUSE_LOAD_PAGE_FAULT, CAUSE_STORE_PAGE_FAULT:
                keep = 1'b1;
            default:
                keep = 1'b0;
        endcase

        r.trap_taken      = 1'b1;
        r.to_supervisor   = to_s;
        // Vectored mode only applies to interrupts; the add wraps at 64 bits.
        r.target_pc       = {tvec[63:2], 2'b00}
                            + ((is_irq && tvec[0]) ? {58'd0, code, 2'b00} : 64'd0);
        r.cause_value     = is_irq ? {1'b1, 59'd0, code} : {60'd0, code};
        r.saved_pc        = rq.current_pc;
        r.trap_value      = (!is_irq && keep) ? rq.fault_value : 64'd0;
        r.previous_mode   = rq.current_mode;
        r.previous_enable = to_s ? rq.super_int_enable : rq.machine_int_enable;
        r.new_mode        = to_s ? MODE_SUPER : MODE_MACHINE;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [63:0] wide_value();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1 << $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic rte_item_t make_request(input logic rq_type, input logic [3:0] code,
                                               input logic [63:0] pc, input logic [63:0] fval,
                                               input logic [11:0] pend, input logic [1:0] mode,
                                               input logic mie, input logic sie);
        rte_item_t rq;
        rq.req_type           = rq_type;
        rq.cause_code         = code;
        rq.current_pc         = pc;
        rq.fault_value        = fval;
        rq.pending_irqs       = pend;
        rq.current_mode       = mode;
        rq.machine_int_enable = mie;
        rq.super_int_enable   = sie;
        return rq;
    endfunction

    function automatic rte_item_t random_request();
        logic [11:0] pend;
        case ($urandom_range(0, 7))
            0: pend = '0;
            1, 2: pend = 12'd1 << $urandom_range(0, 11);
            default: pend = 12'($urandom);
        endcase
        return make_request($urandom_range(0, 1) ? REQ_INTERRUPT : REQ_EXCEPTION,
                            4'($urandom_range(0, 15)), wide_value(), wide_value(), pend,
                            2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
    endfunction

    // Writes all five CSRs back to back, keeping cfg_valid high between them, and
    // then updates the image with the bits each register actually holds.
    task automatic load_config(input logic [63:0] mtvec_w, input logic [63:0] stvec_w,
                               input logic [63:0] edeleg_w, input logic [63:0] ideleg_w,
                               input logic [63:0] ie_w);
        logic [63:0]          word [5];
        logic [CFG_IDX_W-1:0] idx [5];
        word = '{mtvec_w, stvec_w, edeleg_w, ideleg_w, ie_w};
        idx = '{CFG_MTVEC, CFG_STVEC, CFG_EDELEG, CFG_IDELEG, CFG_IE_MASK};
        @(posedge clk);
        for (int k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= word[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        csr_image.mtvec   = mtvec_w;
        csr_image.stvec   = stvec_w;
        csr_image.edeleg  = edeleg_w[15:0];
        csr_image.ideleg  = ideleg_w[11:0];
        csr_image.ie_mask = ie_w[11:0];
    endtask

    // Returns at a falling edge once every queued request has been accepted and
    // every predicted trap entry has come back.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || requests_taken != results_seen);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                      results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Request driver. A stalled request holds its payload; otherwise the driver
    // either idles for a random burst, waits for a full drain, or offers the next
    // request. The prediction is made at the edge where the request is taken.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_traps.push_back(predict_trap(drive_req, csr_image));
                requests_taken <= requests_taken + 1;
            end
            if (!(in_valid && in_stall)) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (drain_hold) begin
                    // Hold off until nothing is on the port and every trap is back.
                    in_valid <= 1'b0;
                    if (!in_valid && requests_taken == results_seen)
                        drain_hold = 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    drive_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= drive_req.req_type;
                    cause_code <= drive_req.cause_code;
                    current_pc <= drive_req.current_pc;
                    fault_value <= drive_req.fault_value;
                    pending_irqs <= drive_req.pending_irqs;
                    current_mode <= drive_req.current_mode;
                    machine_int_enable <= drive_req.machine_int_enable;
                    super_int_enable <= drive_req.super_int_enable;
                    launched++;
                    if (launched % DRAIN_EVERY == 0)
                        drain_hold = 1'b1;
                    if (idle_on && $urandom_range(0, 15) == 0)
                        send_gap = $urandom_range(1, 12);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and output stall generator. Every accepted result is
    // matched against the oldest predicted trap entry, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        rte_result_t got;
        rte_result_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {trap_taken, to_supervisor, target_pc, cause_value, saved_pc,
                       trap_value, previous_mode, previous_enable, new_mode};
                if (expected_traps.size() == 0) begin
                    report_mismatch($sformatf("result with no request outstanding: %0h",
                                              got));
                end else begin
                    want = expected_traps.pop_front();
                    check_field("trap_taken", got.trap_taken, want.trap_taken);
                    check_field("to_supervisor", got.to_supervisor, want.to_supervisor);
                    check_field("target_pc", got.target_pc, want.target_pc);
                    check_field("cause_value", got.cause_value, want.cause_value);
                    check_field("saved_pc", got.saved_pc, want.saved_pc);
                    check_field("trap_value", got.trap_value, want.trap_value);
                    check_field("previous_mode", got.previous_mode, want.previous_mode);
                    check_field("previous_enable", got.previous_enable,
                                want.previous_enable);
                    check_field("new_mode", got.new_mode, want.new_mode);
                end
                results_seen <= results_seen + 1;
            end
            if (recv_gap != 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                // Start a burst of stalled cycles, this one included.
                recv_gap = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any handshake on any channel resets the count of quiet cycles.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: a short directed part, then random phases, each phase
    // starting from an idle block with a fresh set of CSR values.
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] pc_v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset CSRs every interrupt is masked, so a poll never traps and
        // exceptions go to machine mode with a zero vector.
        @(negedge clk);
        pending_reqs.push_back(make_request(REQ_EXCEPTION, 4'd15, '1, '1, '1, MODE_USER,
                                            1'b1, 1'b1));
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, '1, '1, '1, MODE_USER,
                                            1'b1, 1'b1));
        pending_reqs.push_back(make_request(REQ_EXCEPTION, 4'd0, '0, '0, '0, MODE_MACHINE,
                                            1'b0, 1'b0));
        wait_drained();

        // Directed CSRs: a vectored machine base near the top of the address space so
        // that the interrupt offset wraps, a vectored supervisor base with bit 1 set,
        // and delegation registers written with upper bits that must be dropped.
        load_config(64'hFFFF_FFFF_FFFF_FFFD, 64'h0000_0000_8000_0103,
                    64'hFFFF_FFFF_FFFF_A5A5, 64'hFFFF_FFFF_FFFF_F333, 64'h0000_0000_0000_FFFF);
        @(negedge clk);
        // Every exception cause, walking through all four mode encodings, so that the
        // reserved mode and machine mode both meet delegated causes.
        for (int c = 0; c < 16; c++) begin
            pc_v = c[0] ? 64'd0 : '1;
            pending_reqs.push_back(make_request(REQ_EXCEPTION, 4'(c), pc_v, ~pc_v, 12'hFFF,
                                                2'(c), c[0], c[1]));
        end
        // Highest priority interrupt in machine mode with the enable set.
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, 64'h1234, '1, 12'hFFF,
                                            MODE_MACHINE, 1'b1, 1'b0));
        // Machine mode with the machine enable clear: nothing qualifies.
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, 64'h1234, '1, 12'hFFF,
                                            MODE_MACHINE, 1'b0, 1'b1));
        // Only delegated interrupts pending, supervisor mode, enable set and clear.
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, '1, '1, 12'h333,
                                            MODE_SUPER, 1'b0, 1'b1));
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, '1, '1, 12'h333,
                                            MODE_SUPER, 1'b1, 1'b0));
        // Lowest priority interrupt alone, taken from user mode with enables clear.
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, '0, '1, 12'h010,
                                            MODE_USER, 1'b0, 1'b0));
        // Bits that are never selected, even though they are enabled.
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, '0, '1, 12'h444,
                                            MODE_USER, 1'b1, 1'b1));
        // Reserved mode 2 ranks below machine for the global enable check.
        pending_reqs.push_back(make_request(REQ_INTERRUPT, 4'd0, '1, '1, 12'h880,
                                            2'd2, 1'b0, 1'b0));
        wait_drained();

        for (int p = 0; p < NUM_RAND_PHASES; p++) begin
            case (p)
                0: load_config('1, '1, '1, '1, '1);
                1: load_config('0, '0, '0, '0, '1);
                default: load_config(wide_value(), wide_value(), {$urandom, $urandom},
                                     {$urandom, $urandom}, {$urandom, $urandom | $urandom});
            endcase
            @(negedge clk);
            // The last phase runs with both sides flowing at full rate.
            idle_on = p != NUM_RAND_PHASES - 1;
            for (int n = 0; n < PHASE_REQS; n++)
                pending_reqs.push_back(random_request());
            wait_drained();
        end

        // Let the clock run on to catch any stray result.
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
